>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define BCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define BCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

  typedef enum logic [1:0] {
    MODE_SIMILAR = 2'd0,
    MODE_LOWER   = 2'd1,
    MODE_HIGHER  = 2'd2
  } mode_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_THR = 1'd1;

  localparam logic [10:0] SMALL_THR_RESET = 11'd102;
  localparam logic [7:0]  MIN_TASKS       = 8'd2;

  localparam logic [14:0] SUM_UTIL_MAX  = 15'h7FFF;
  localparam logic [14:0] SUM_CAP_MAX   = 15'h7FFF;
  localparam logic [11:0] SUM_TASKS_MAX = 12'hFFF;
  localparam logic [4:0]  ACTIVE_MAX    = 5'h1F;

  typedef struct packed {
    logic [3:0]  cpu_index;
    logic [10:0] dst_capacity;
    logic [10:0] cpu_capacity;
    logic        cpu_is_active;
    logic [10:0] cpu_utilization;
    logic [7:0]  fair_run_count;
    logic [10:0] current_task_util;
    logic        is_overutilized;
    logic        balance_in_progress;
    logic [7:0]  big_task_count;
    logic        last_cpu;
  } in_beat_t;

  typedef struct packed {
    logic       busiest_valid;
    logic [3:0] busiest_index;
  } out_beat_t;

  typedef struct packed {
    logic        rotation;
    logic [10:0] small_thr;
  } cfg_t;

  // Group totals and choice as they stand after the group's last record.
  typedef struct packed {
    mode_t       mode;
    logic        rotation;
    logic        found;
    logic [3:0]  cpu;
    logic        big_zero;
    logic [14:0] sum_util;
    logic [14:0] sum_cap;
    logic [11:0] sum_tasks;
    logic [4:0]  active;
  } group_sum_t;

endpackage

>>> src/bcs_in_if.sv
`timescale 1ns / 1ps

interface bcs_in_if;
  logic             valid;
  logic             ready;
  bcs_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bcs_out_if.sv
`timescale 1ns / 1ps

interface bcs_out_if;
  logic              valid;
  logic              ready;
  bcs_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bcs_scan.sv
`timescale 1ns / 1ps

module bcs_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  bcs_pkg::in_beat_t   beat,
  input  bcs_pkg::cfg_t       cfg,
  output bcs_pkg::group_sum_t summary
);

  logic          awaiting_r, awaiting_nxt;
  bcs_pkg::mode_t mode_r, mode_nxt;
  logic [10:0]   best_util_r, best_util_nxt;
  logic [3:0]    best_cpu_r, best_cpu_nxt;
  logic          found_r, found_nxt;
  logic [7:0]    best_big_r, best_big_nxt;
  logic [14:0]   sum_util_r, sum_util_nxt;
  logic [14:0]   sum_cap_r, sum_cap_nxt;
  logic [11:0]   sum_tasks_r, sum_tasks_nxt;
  logic [4:0]    active_r, active_nxt;

  bcs_pkg::mode_t mode_eff;
  logic          add_totals;
  logic          cand;
  logic          take;
  logic          enough_tasks;
  logic          over_ok;
  logic [15:0]   util_add;
  logic [15:0]   cap_add;
  logic [12:0]   tasks_add;
  logic [5:0]    active_add;

  // The first record of a group fixes the mode.
  always_comb begin
    if (awaiting_r) begin
      if (beat.dst_capacity == beat.cpu_capacity) begin
        mode_eff = bcs_pkg::MODE_SIMILAR;
      end else if (beat.dst_capacity < beat.cpu_capacity) begin
        mode_eff = bcs_pkg::MODE_LOWER;
      end else begin
        mode_eff = bcs_pkg::MODE_HIGHER;
      end
    end else begin
      mode_eff = mode_r;
    end
  end

  assign add_totals   = (mode_eff != bcs_pkg::MODE_SIMILAR) && beat.cpu_is_active;
  assign enough_tasks = beat.fair_run_count >= bcs_pkg::MIN_TASKS;
  assign over_ok      = cfg.rotation || beat.is_overutilized;

  always_comb begin
    case (mode_eff)
      bcs_pkg::MODE_SIMILAR: begin
        cand = enough_tasks;
      end
      bcs_pkg::MODE_HIGHER: begin
        cand = beat.cpu_is_active && enough_tasks &&
               !(beat.fair_run_count == bcs_pkg::MIN_TASKS &&
                 beat.current_task_util < cfg.small_thr) && over_ok;
      end
      bcs_pkg::MODE_LOWER: begin
        cand = beat.cpu_is_active && !beat.balance_in_progress &&
               !(!enough_tasks && beat.big_task_count == 8'd0) && over_ok;
      end
      default: begin
        cand = 1'b0;
      end
    endcase
  end

  // Later ties win.
  assign take = cand && (beat.cpu_utilization >= best_util_r);

  assign util_add   = {1'b0, sum_util_r} + {5'd0, beat.cpu_utilization};
  assign cap_add    = {1'b0, sum_cap_r} + {5'd0, beat.cpu_capacity};
  assign tasks_add  = {1'b0, sum_tasks_r} + {5'd0, beat.fair_run_count};
  assign active_add = {1'b0, active_r} + 6'd1;

  always_comb begin
    sum_util_nxt  = sum_util_r;
    sum_cap_nxt   = sum_cap_r;
    sum_tasks_nxt = sum_tasks_r;
    active_nxt    = active_r;
    if (add_totals) begin
      sum_util_nxt  = util_add[15]  ? bcs_pkg::SUM_UTIL_MAX  : util_add[14:0];
      sum_cap_nxt   = cap_add[15]   ? bcs_pkg::SUM_CAP_MAX   : cap_add[14:0];
      sum_tasks_nxt = tasks_add[12] ? bcs_pkg::SUM_TASKS_MAX : tasks_add[11:0];
      active_nxt    = active_add[5] ? bcs_pkg::ACTIVE_MAX    : active_add[4:0];
    end
    best_util_nxt = take ? beat.cpu_utilization : best_util_r;
    best_cpu_nxt  = take ? beat.cpu_index : best_cpu_r;
    found_nxt     = take || found_r;
    best_big_nxt  = (take && mode_eff == bcs_pkg::MODE_LOWER) ? beat.big_task_count
                                                              : best_big_r;
    mode_nxt      = mode_eff;
    awaiting_nxt  = 1'b0;
  end

  always_comb begin
    summary.mode      = mode_eff;
    summary.rotation  = cfg.rotation;
    summary.found     = found_nxt;
    summary.cpu       = best_cpu_nxt;
    summary.big_zero  = best_big_nxt == 8'd0;
    summary.sum_util  = sum_util_nxt;
    summary.sum_cap   = sum_cap_nxt;
    summary.sum_tasks = sum_tasks_nxt;
    summary.active    = active_nxt;
  end

  // Advance per record; drop the group back to its idle values after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || (go && beat.last_cpu)) begin
      awaiting_r  <= 1'b1;
      mode_r      <= bcs_pkg::MODE_SIMILAR;
      best_util_r <= 11'd0;
      best_cpu_r  <= 4'd0;
      found_r     <= 1'b0;
      best_big_r  <= 8'd0;
      sum_util_r  <= 15'd0;
      sum_cap_r   <= 15'd0;
      sum_tasks_r <= 12'd0;
      active_r    <= 5'd0;
    end else if (go) begin
      awaiting_r  <= awaiting_nxt;
      mode_r      <= mode_nxt;
      best_util_r <= best_util_nxt;
      best_cpu_r  <= best_cpu_nxt;
      found_r     <= found_nxt;
      best_big_r  <= best_big_nxt;
      sum_util_r  <= sum_util_nxt;
      sum_cap_r   <= sum_cap_nxt;
      sum_tasks_r <= sum_tasks_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

>>> src/bcs_verdict.sv
`timescale 1ns / 1ps

module bcs_verdict (
  input  bcs_pkg::group_sum_t summary,
  output bcs_pkg::out_beat_t  result
);

  logic [17:0] util_x5;
  logic [17:0] cap_x4;
  logic        light_load;
  logic        veto_mode;
  logic        sel;

  // util*1280 < cap*1024 reduces to util*5 < cap*4.
  assign util_x5    = {1'b0, summary.sum_util, 2'b00} + {3'd0, summary.sum_util};
  assign cap_x4     = {1'b0, summary.sum_cap, 2'b00};
  assign light_load = (summary.sum_tasks <= {7'd0, summary.active}) || (util_x5 < cap_x4);

  assign veto_mode = (summary.mode == bcs_pkg::MODE_HIGHER) ||
                     (summary.mode == bcs_pkg::MODE_LOWER && summary.big_zero);

  assign sel = summary.found && !(!summary.rotation && veto_mode && light_load);

  assign result.busiest_valid = sel;
  assign result.busiest_index = sel ? summary.cpu : 4'd0;

endmodule

>>> src/busiest_cpu_selector_top.sv
`timescale 1ns / 1ps
// Busiest CPU selector.
// in_ch takes one beat per candidate CPU of a source group; the beat with
// last_cpu set closes the group. out_ch gives one beat per group: the
// chosen CPU in busiest_index with busiest_valid set, or busiest_valid
// clear and index 0 when nothing qualifies. Beats without last_cpu give
// no output beat.
// Throughput: one input beat per cycle unless an out_ch stall backs up
// into in_ch. Each beat is held in the input register, where the group
// state is updated; the group summary then moves to a snapshot register,
// where the load veto is evaluated, and lands in the output register.
// Stalls: when out_ch.ready is low the output register holds; the
// snapshot register takes the next closing summary, then the input
// register holds one more beat of any kind and in_ch.ready drops.
// Non-closing beats keep flowing while an older result waits, as long
// as the snapshot stage is free.
// Reset (rst_n low, synchronous) empties the pipeline, clears the group
// state, turns rotation off and sets the small task threshold to 102.
// cfg_we writes register cfg_index (0 rotation, 1 threshold) from
// cfg_wdata; write only while no group is in flight.

`include "assert_macros.svh"

module busiest_cpu_selector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bcs_in_if.sink                         in_ch,
  bcs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bcs_pkg::cfg_t       cfg_r;

  logic                s1_valid_r, s1_valid_nxt;
  bcs_pkg::in_beat_t   s1_beat_r;
  logic                s2_valid_r, s2_valid_nxt;
  bcs_pkg::group_sum_t s2_sum_r;
  logic                out_valid_r, out_valid_nxt;
  bcs_pkg::out_beat_t  out_beat_r;

  logic                out_free;
  logic                s2_free;
  logic                s1_go;
  logic                in_acc;
  logic                s1_close;
  bcs_pkg::group_sum_t scan_sum;
  bcs_pkg::out_beat_t  verdict;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation  <= 1'b0;
      cfg_r.small_thr <= bcs_pkg::SMALL_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bcs_pkg::CFG_ROTATION:  cfg_r.rotation  <= cfg_wdata[0];
        bcs_pkg::CFG_SMALL_THR: cfg_r.small_thr <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Stage flow: each stage moves when the one after it has room.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s2_free      = !s2_valid_r || out_free;
  assign s1_go        = s1_valid_r && s2_free;
  assign s1_close     = s1_go && s1_beat_r.last_cpu;
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_go);
  assign s2_valid_nxt  = s2_free ? s1_close : s2_valid_r;
  assign out_valid_nxt = out_free ? s2_valid_r : out_valid_r;

  bcs_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (s1_go),
    .beat    (s1_beat_r),
    .cfg     (cfg_r),
    .summary (scan_sum)
  );

  bcs_verdict u_verdict (
    .summary (s2_sum_r),
    .result  (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_beat_r <= in_ch.data;
    end
    if (s1_close) begin
      s2_sum_r <= scan_sum;
    end
    if (out_free && s2_valid_r) begin
      out_beat_r <= verdict;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_beat_r;

  `BCS_ASSERT_NOW(a_none_zero_index,
    out_valid_r && !out_beat_r.busiest_valid, out_beat_r.busiest_index == 4'd0)
  `BCS_ASSERT_NEXT(a_close_reaches_s2, s1_close, s2_valid_r)
  `BCS_ASSERT_NEXT(a_s2_holds_on_stall,
    s2_valid_r && out_valid_r && !out_ch.ready, s2_valid_r)
  `BCS_ASSERT_NOW(a_ready_low_means_busy, !in_ch.ready, s1_valid_r && s2_valid_r)

endmodule
